// ===== rtl/core/dwsm_pkg.sv =====
`timescale 1ns / 1ps

package dwsm_pkg;

  localparam int SLOTS      = 4;
  localparam int ADDR_WIDTH = 64;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PACK_SLOTS = (SLOTS < 4) ? SLOTS : 4;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ACC_READ_WRITE = 2'b11;
  localparam logic [1:0] ACC_WRITE_ONLY = 2'b01;

  localparam logic [1:0] SZ_BYTE  = 2'b00;
  localparam logic [1:0] SZ_HALF  = 2'b01;
  localparam logic [1:0] SZ_QUAD  = 2'b10;
  localparam logic [1:0] SZ_WORD  = 2'b11;

  localparam logic [7:0] LEN_2 = 8'd2;
  localparam logic [7:0] LEN_4 = 8'd4;
  localparam logic [7:0] LEN_8 = 8'd8;

  typedef struct packed {
    logic exec;
  } ctrl_t;

  function automatic logic [1:0] size_code(input logic [7:0] len);
    logic [1:0] code;
    unique case (len)
      LEN_8:   code = SZ_QUAD;
      LEN_4:   code = SZ_WORD;
      LEN_2:   code = SZ_HALF;
      default: code = SZ_BYTE;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/dwsm_ctrl.sv =====
`timescale 1ns / 1ps

module dwsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dwsm_pkg::ctrl_t ctrl
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_HOLD  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready  = (state == ST_EMPTY) || out_ready;
  assign out_valid = (state == ST_HOLD);
  assign ctrl.exec = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (ctrl.exec) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (ctrl.exec) state_next = ST_HOLD;
        else if (out_ready) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/dwsm_datapath.sv =====
`timescale 1ns / 1ps

module dwsm_datapath (
  input  logic            clk,
  input  logic            rst,
  input  dwsm_pkg::ctrl_t ctrl,
  input  logic            cmd,
  input  logic [63:0]     address,
  input  logic [7:0]      length,
  input  logic            read_access,
  output logic            success,
  output logic [1:0]      slot,
  output logic [31:0]     control_word
);

  logic [dwsm_pkg::SLOTS-1:0]           slot_enable;
  logic [1:0]                           slot_access [dwsm_pkg::SLOTS];
  logic [1:0]                           slot_size_code [dwsm_pkg::SLOTS];
  logic [dwsm_pkg::ADDR_WIDTH-1:0]      slot_address [dwsm_pkg::SLOTS];

  logic [dwsm_pkg::SLOTS-1:0]           enable_next;
  logic [dwsm_pkg::ADDR_WIDTH-1:0]      req_addr;
  logic [1:0]                           req_acc;
  logic [1:0]                           req_sz;
  logic [dwsm_pkg::SLOTS-1:0]           hit;
  logic                                 hit_any;
  logic [dwsm_pkg::SLOT_IDX_W-1:0]      hit_idx;
  logic                                 free_any;
  logic [dwsm_pkg::SLOT_IDX_W-1:0]      free_idx;
  logic                                 fill;
  logic                                 ok;
  logic [dwsm_pkg::SLOT_IDX_W-1:0]      res_idx;
  logic [31:0]                          res_idx_wide;
  logic [31:0]                          word_next;

  assign req_addr = address[dwsm_pkg::ADDR_WIDTH-1:0];
  assign req_acc  = read_access ? dwsm_pkg::ACC_READ_WRITE : dwsm_pkg::ACC_WRITE_ONLY;
  assign req_sz   = dwsm_pkg::size_code(length);

  always_comb begin
    for (int i = 0; i < dwsm_pkg::SLOTS; i++) begin
      hit[i] = slot_enable[i] && (slot_access[i] == req_acc) &&
               (slot_size_code[i] == req_sz) && (slot_address[i] == req_addr);
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = dwsm_pkg::SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = dwsm_pkg::SLOT_IDX_W'(i);
      end
      if (!slot_enable[i]) begin
        free_any = 1'b1;
        free_idx = dwsm_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    enable_next = slot_enable;
    fill        = 1'b0;
    ok          = 1'b0;
    res_idx     = '0;
    case (cmd)
      dwsm_pkg::CMD_REMOVE: begin
        if (hit_any) begin
          enable_next[hit_idx] = 1'b0;
          ok                   = 1'b1;
          res_idx              = hit_idx;
        end
      end
      default: begin
        if (hit_any) begin
          ok      = 1'b1;
          res_idx = hit_idx;
        end else if (free_any) begin
          enable_next[free_idx] = 1'b1;
          fill                  = 1'b1;
          ok                    = 1'b1;
          res_idx               = free_idx;
        end
      end
    endcase
  end

  assign res_idx_wide = 32'(res_idx);

  always_comb begin
    word_next = '0;
    for (int i = 0; i < dwsm_pkg::PACK_SLOTS; i++) begin
      word_next[2*i] = enable_next[i];
      if (fill && (free_idx == dwsm_pkg::SLOT_IDX_W'(i))) begin
        word_next[16+4*i +: 2] = req_acc;
        word_next[18+4*i +: 2] = req_sz;
      end else begin
        word_next[16+4*i +: 2] = slot_access[i];
        word_next[18+4*i +: 2] = slot_size_code[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enable <= '0;
      for (int i = 0; i < dwsm_pkg::SLOTS; i++) begin
        slot_access[i]    <= '0;
        slot_size_code[i] <= '0;
      end
    end else if (ctrl.exec) begin
      slot_enable <= enable_next;
      if (fill) begin
        slot_access[free_idx]    <= req_acc;
        slot_size_code[free_idx] <= req_sz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && fill) begin
      slot_address[free_idx] <= req_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      success      <= ok;
      slot         <= res_idx_wide[1:0];
      control_word <= word_next;
    end
  end

endmodule

// ===== rtl/core/debug_watchpoint_slot_manager.sv =====
`timescale 1ns / 1ps
// Result: registered, and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; all slots are compared in parallel and
// the slot table updates in the same cycle, so a request enters each cycle
// the output register is free or being drained.
// Reset: synchronous; all slots disabled, access and length codes cleared.

module debug_watchpoint_slot_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [63:0] address,
  input  logic [7:0]  length,
  input  logic        read_access,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [1:0]  slot,
  output logic [31:0] control_word
);

  dwsm_pkg::ctrl_t ctrl;

  dwsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  dwsm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cmd          (cmd),
    .address      (address),
    .length       (length),
    .read_access  (read_access),
    .success      (success),
    .slot         (slot),
    .control_word (control_word)
  );

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (slot == 2'd0))
    else $error("failed request reports nonzero slot");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule
